/* rtl/tse_pkg.sv */
// Shared types and register map for the transponder squawk entry block.
package tse_pkg;

  localparam int unsigned SquawkW = 14;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CursorW = 3;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned NumKeys = 8;
  localparam int unsigned AddrW = 4;

  localparam logic [SquawkW-1:0] SquawkMax = 14'd9999;

  localparam logic [SquawkW-1:0] VfrCodeRst      = 14'd7000;
  localparam logic [TimerW-1:0]  EditTimeoutRst  = 16'd5000;
  localparam logic [TimerW-1:0]  IdentTimeoutRst = 16'd18000;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] RegVfrCode      = 2'd0;
  localparam logic [1:0] RegEditTimeout  = 2'd1;
  localparam logic [1:0] RegIdentTimeout = 2'd2;

  // cursor codes
  localparam logic [CursorW-1:0] CurIdle  = 3'd0;
  localparam logic [CursorW-1:0] CurFirst = 3'd1;
  localparam logic [CursorW-1:0] CurLast  = 3'd4;

  // four BCD digits, index 0 is the thousands digit
  typedef logic [NumDigits-1:0][3:0] digits_t;

  typedef struct packed {
    logic       mode_press;
    logic       ident_press;
    logic       vfr_press;
    logic [7:0] digit_press;
  } in_beat_t;

  typedef struct packed {
    logic [SquawkW-1:0] squawk;
    logic [CursorW-1:0] cursor;
    logic               ident_active;
    logic               mode_c;
    logic               redraw;
  } out_beat_t;

endpackage

/* rtl/tse_vfr_bcd.sv */
// Converts the VFR code into four decimal digits, loaded together with the VFR code register.
module tse_vfr_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [tse_pkg::SquawkW-1:0]   code_i,
  output tse_pkg::digits_t              digits_o
);
  import tse_pkg::*;

  logic [SquawkW-1:0] sat;
  logic [28:0]        p10;
  logic [25:0]        p100;
  logic [26:0]        p1000;
  logic [9:0]         q10;
  logic [6:0]         q100;
  logic [3:0]         q1000;
  logic [6:0]         hu_w;
  logic [9:0]         te_w;
  logic [SquawkW-1:0] un_w;
  digits_t            digits_d, digits_q;

  // reciprocal multiplies, exact for 0..9999
  always_comb begin
    sat   = (code_i > SquawkMax) ? SquawkMax : code_i;
    p10   = {15'd0, sat} * 29'd52429;
    p100  = {12'd0, sat} * 26'd5243;
    p1000 = {13'd0, sat} * 27'd8389;
    q10   = p10[28:19];
    q100  = p100[25:19];
    q1000 = p1000[26:23];
    hu_w  = q100 - ({3'd0, q1000} * 7'd10);
    te_w  = q10 - ({3'd0, q100} * 10'd10);
    un_w  = sat - ({4'd0, q10} * 14'd10);
    digits_d = {un_w[3:0], te_w[3:0], hu_w[3:0], q1000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= {4'd0, 4'd0, 4'd0, 4'd7};
    end else if (wr_i) begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

/* rtl/transponder_squawk_entry.sv */
// Top level of the transponder squawk entry panel.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one service pass
//   per beat: key press flags for mode, IDENT, VFR and digits 0 to 7.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one beat per
//   pass: squawk, cursor, ident and Mode C flags, and a redraw flag.
//   An accepted beat sits in the input register, then the pass is evaluated
//   combinationally into the result register, which raises out_valid_o. One
//   pass per cycle is sustained while the receiver takes results; the input
//   register and the result register form a two-deep pipe.
//   When the receiver stalls, the result holds, the input register fills and
//   in_ready_o drops until the result is taken.
//   Reset clears the panel state (squawk 0000, no editing, ident off, standby)
//   and loads the register defaults: VFR code 7000, edit timeout 5000, ident
//   timeout 18000. The VFR code digits are loaded with the register itself.
//   Registers sit on an APB-style port at byte addresses 0, 4 and 8.
module transponder_squawk_entry (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tse_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tse_pkg::out_beat_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tse_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tse_pkg::*;

  // config registers
  logic [SquawkW-1:0] vfr_code_q;
  logic [TimerW-1:0]  edit_timeout_q, ident_timeout_q;
  logic               cfg_wr;
  logic               vfr_wr;
  logic [1:0]         cfg_idx;
  digits_t            vfr_digits;

  // panel state
  digits_t            digits_q, digits_d;
  logic [CursorW-1:0] pos_q, pos_d;
  logic [TimerW-1:0]  edit_timer_q, edit_timer_d;
  logic [TimerW-1:0]  ident_timer_q, ident_timer_d;
  logic               identing_q, identing_d;
  logic               mode_c_q, mode_c_d;

  // pipe
  in_beat_t           in_q;
  logic               in_valid_q;
  out_beat_t          out_q, out_d;
  logic               out_valid_q;
  logic               advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign vfr_wr  = cfg_wr && (cfg_idx == RegVfrCode);

  always_comb begin
    case (cfg_idx)
      RegVfrCode:      prdata = {18'd0, vfr_code_q};
      RegEditTimeout:  prdata = {16'd0, edit_timeout_q};
      RegIdentTimeout: prdata = {16'd0, ident_timeout_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vfr_code_q      <= VfrCodeRst;
      edit_timeout_q  <= EditTimeoutRst;
      ident_timeout_q <= IdentTimeoutRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegVfrCode:      vfr_code_q      <= pwdata[SquawkW-1:0];
        RegEditTimeout:  edit_timeout_q  <= pwdata[TimerW-1:0];
        RegIdentTimeout: ident_timeout_q <= pwdata[TimerW-1:0];
        default: ;
      endcase
    end
  end

  tse_vfr_bcd u_vfr_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (vfr_wr),
    .code_i   (pwdata[SquawkW-1:0]),
    .digits_o (vfr_digits)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // one pass over the registered beat
  always_comb begin
    logic [3:0]        p;
    logic              any_digit;
    logic              edit_exp, ident_exp;
    logic [TimerW-1:0] et, it;

    mode_c_d   = mode_c_q ^ in_q.mode_press;
    identing_d = identing_q;
    it         = ident_timer_q;
    if (in_q.ident_press) begin
      identing_d = 1'b1;
      it         = ident_timeout_q;
    end

    digits_d = digits_q;
    p        = {1'b0, pos_q};
    et       = edit_timer_q;
    if (in_q.vfr_press) begin
      digits_d = vfr_digits;
      p        = 4'd0;
      et       = '0;
    end

    // digit keys in ascending order, each overwrites the digit under the cursor
    for (int k = 0; k < NumKeys; k++) begin
      if (in_q.digit_press[k]) begin
        if (p == 4'd0) begin
          p = 4'd1;
        end
        if (p <= 4'(CurLast)) begin
          digits_d[p[1:0] - 2'd1] = 4'(k);
        end else begin
          digits_d[NumDigits-1] = 4'(k);
        end
        p = p + 4'd1;
        if (p >= 4'd5) begin
          p = 4'd1;
        end
      end
    end
    any_digit = |in_q.digit_press;
    if (any_digit) begin
      et = edit_timeout_q;
    end

    edit_exp = 1'b0;
    if (et != '0) begin
      et       = et - 16'd1;
      edit_exp = (et == '0);
    end
    if (edit_exp) begin
      p = 4'd0;
    end

    ident_exp = 1'b0;
    if (it != '0) begin
      it        = it - 16'd1;
      ident_exp = (it == '0);
    end
    if (ident_exp) begin
      identing_d = 1'b0;
    end

    pos_d         = p[CursorW-1:0];
    edit_timer_d  = et;
    ident_timer_d = it;

    out_d.squawk = ({10'd0, digits_d[0]} * 14'd1000) + ({10'd0, digits_d[1]} * 14'd100)
                 + ({10'd0, digits_d[2]} * 14'd10) + {10'd0, digits_d[3]};
    out_d.cursor       = pos_d;
    out_d.ident_active = identing_d;
    out_d.mode_c       = mode_c_d;
    out_d.redraw       = in_q.ident_press || in_q.vfr_press || any_digit
                      || edit_exp || ident_exp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      digits_q      <= '0;
      pos_q         <= CurIdle;
      edit_timer_q  <= '0;
      ident_timer_q <= '0;
      identing_q    <= 1'b0;
      mode_c_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        digits_q      <= digits_d;
        pos_q         <= pos_d;
        edit_timer_q  <= edit_timer_d;
        ident_timer_q <= ident_timer_d;
        identing_q    <= identing_d;
        mode_c_q      <= mode_c_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* bench/transponder_squawk_entry_test.sv */
// Self-checking testbench for the transponder squawk entry panel.
`timescale 1ns / 1ps

module transponder_squawk_entry_test;
  import tse_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned LimitCycles = 200_000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned MaxPrinted  = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  transponder_squawk_entry dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // panel copy kept by the bench
  logic [SquawkW-1:0] vfr_cfg = VfrCodeRst;
  logic [TimerW-1:0]  edit_cfg = EditTimeoutRst;
  logic [TimerW-1:0]  ident_cfg = IdentTimeoutRst;
  logic [3:0]         dig [NumDigits];
  logic [CursorW-1:0] pos = CurIdle;
  logic [TimerW-1:0]  edit_left = '0;
  logic [TimerW-1:0]  ident_left = '0;
  logic               identing = 1'b0;
  logic               mode_c_on = 1'b0;

  in_beat_t  press_q [$];
  out_beat_t panel_q [$];
  out_beat_t want;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned miss_count = 0;
  int unsigned beats_seen = 0;
  logic        rx_hold = 1'b0;
  event        hold_off_start;

  initial begin
    for (int i = 0; i < NumDigits; i++) dig[i] = 4'd0;
  end

  initial begin
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_miss(input string msg);
    if (miss_count < MaxPrinted) $display("MISMATCH beat %0d: %s", beats_seen, msg);
    miss_count++;
  endtask

  // One service pass of the panel: mode, IDENT, VFR, digits 0..7, then timers.
  function automatic out_beat_t service_pass(input in_beat_t b);
    out_beat_t          res;
    logic               redraw;
    logic [SquawkW-1:0] v;
    logic [1:0]         slot;
    redraw = 1'b0;
    if (b.mode_press) mode_c_on = !mode_c_on;
    if (b.ident_press) begin
      identing = 1'b1;
      ident_left = ident_cfg;
      redraw = 1'b1;
    end
    if (b.vfr_press) begin
      v = (vfr_cfg > SquawkMax) ? SquawkMax : vfr_cfg;
      dig[0] = 4'(v / 1000);
      dig[1] = 4'((v / 100) % 10);
      dig[2] = 4'((v / 10) % 10);
      dig[3] = 4'(v % 10);
      pos = CurIdle;
      edit_left = '0;
      redraw = 1'b1;
    end
    for (int k = 0; k < NumKeys; k++) begin
      if (b.digit_press[k]) begin
        edit_left = edit_cfg;
        if (pos == CurIdle) pos = CurFirst;
        slot = (pos >= CurFirst && pos <= CurLast) ? 2'(pos - CurFirst) : 2'(NumDigits - 1);
        dig[slot] = 4'(k);
        pos = pos + 3'd1;
        if (pos > CurLast) pos = CurFirst;
        redraw = 1'b1;
      end
    end
    if (edit_left != '0) begin
      edit_left = edit_left - 16'd1;
      if (edit_left == '0) begin
        pos = CurIdle;
        redraw = 1'b1;
      end
    end
    if (ident_left != '0) begin
      ident_left = ident_left - 16'd1;
      if (ident_left == '0) begin
        identing = 1'b0;
        redraw = 1'b1;
      end
    end
    res.squawk = 14'(dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3]);
    res.cursor = pos;
    res.ident_active = identing;
    res.mode_c = mode_c_on;
    res.redraw = redraw;
    return res;
  endfunction

  function automatic in_beat_t keys(input logic m, input logic i, input logic v,
                                    input logic [7:0] d);
    in_beat_t b;
    b.mode_press = m;
    b.ident_press = i;
    b.vfr_press = v;
    b.digit_press = d;
    return b;
  endfunction

  // mostly single digit presses and quiet passes, so that edits and timeouts play out
  function automatic in_beat_t random_pass();
    in_beat_t    b;
    logic [10:0] raw;
    int unsigned r;
    b = '0;
    r = $urandom_range(99);
    raw = 11'($urandom);
    if (r < 35) b.digit_press = 8'h01 << $urandom_range(7);
    else if (r < 50) b = '0;
    else if (r < 58) b.mode_press = 1'b1;
    else if (r < 66) b.ident_press = 1'b1;
    else if (r < 72) b.vfr_press = 1'b1;
    else if (r < 88) b = raw;
    else b.digit_press = raw[7:0];
    return b;
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegVfrCode:      vfr_cfg = val[SquawkW-1:0];
      RegEditTimeout:  edit_cfg = val[TimerW-1:0];
      RegIdentTimeout: ident_cfg = val[TimerW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_panel(input logic [31:0] vfr, input logic [31:0] edit_to,
                           input logic [31:0] ident_to);
    reg_write(RegVfrCode, vfr);
    reg_write(RegEditTimeout, edit_to);
    reg_write(RegIdentTimeout, ident_to);
  endtask

  task automatic await_drain();
    @(negedge clk_i);
    while (press_q.size() != 0 || in_valid_i || panel_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(input int n, input int unsigned idle, input int unsigned stall);
    src_idle_pct = idle;
    sink_stall_pct = stall;
    for (int i = 0; i < n; i++) press_q.push_back(random_pass());
    await_drain();
  endtask

  // driver: one pass beat at a time, held until taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) panel_q.push_back(service_pass(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (press_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= press_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats against the predicted panel state
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (panel_q.size() == 0) begin
          report_miss("result beat with no pass pending");
        end else begin
          want = panel_q.pop_front();
          if (out_data_o.squawk !== want.squawk)
            report_miss($sformatf("squawk %0d, want %0d", out_data_o.squawk, want.squawk));
          if (out_data_o.cursor !== want.cursor)
            report_miss($sformatf("cursor %0d, want %0d", out_data_o.cursor, want.cursor));
          if (out_data_o.ident_active !== want.ident_active)
            report_miss($sformatf("ident_active %b, want %b", out_data_o.ident_active,
                                  want.ident_active));
          if (out_data_o.mode_c !== want.mode_c)
            report_miss($sformatf("mode_c %b, want %b", out_data_o.mode_c, want.mode_c));
          if (out_data_o.redraw !== want.redraw)
            report_miss($sformatf("redraw %b, want %b", out_data_o.redraw, want.redraw));
        end
        beats_seen++;
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long receiver hold-off so the pipe fills and input backs up
  always begin
    @(hold_off_start);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: VFR 7000, long timeouts
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h00));
    press_q.push_back(keys(1'b1, 1'b0, 1'b0, 8'h00));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h02));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'hFF));  // all eight keys, cursor wraps twice
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h80));
    press_q.push_back(keys(1'b0, 1'b1, 1'b0, 8'h00));
    press_q.push_back(keys(1'b0, 1'b0, 1'b1, 8'h00));
    press_q.push_back(keys(1'b0, 1'b0, 1'b1, 8'h81));  // VFR then digits restart at thousands
    press_q.push_back(keys(1'b1, 1'b1, 1'b1, 8'hFF));
    press_q.push_back(keys(1'b1, 1'b0, 1'b0, 8'h00));
    await_drain();

    // out-of-range VFR code saturates; timers of one expire in the loading pass
    set_panel(32'h3FFF, 32'd1, 32'd1);
    press_q.push_back(keys(1'b0, 1'b0, 1'b1, 8'h00));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h08));
    press_q.push_back(keys(1'b0, 1'b1, 1'b0, 8'h00));
    press_q.push_back(keys(1'b0, 1'b1, 1'b0, 8'h10));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h00));
    await_drain();

    // zero timeouts never expire
    set_panel(32'd0, 32'd0, 32'd0);
    press_q.push_back(keys(1'b0, 1'b0, 1'b1, 8'h00));
    press_q.push_back(keys(1'b0, 1'b1, 1'b0, 8'h40));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h00));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h24));
    press_q.push_back(keys(1'b0, 1'b0, 1'b0, 8'h00));
    await_drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) set_panel(32'd9999, 32'd65535, 32'd65535);
      else set_panel((p % 2) ? $urandom_range(9999) : $urandom_range(16383),
                     $urandom_range(15), $urandom_range(15));
      case (p % 4)
        0: run_random(115, 0, 0);
        1: run_random(115, 53, 0);
        2: run_random(115, 0, 53);
        default: run_random(115, 11, 11);
      endcase
    end

    set_panel($urandom_range(9999), $urandom_range(1, 8), $urandom_range(1, 8));
    src_idle_pct = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < 40; i++) press_q.push_back(random_pass());
    @(posedge clk_i);
    -> hold_off_start;
    await_drain();

    repeat (4) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
